// ----- rtl/core/rar_pkg.sv -----
// ----------------------------------------------------------------------------
// rar_pkg
// Types and constants shared by the rational arithmetic reduction block.
// ----------------------------------------------------------------------------
package rar_pkg;

	localparam int DEF_OPERAND_WIDTH = 32;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZDIV = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	typedef enum logic [1:0] {
		FN_ADD = 2'd0,
		FN_SUB = 2'd1,
		FN_MUL = 2'd2,
		FN_DIV = 2'd3
	} func_t;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] a_num;
		logic [31:0]        a_den;
		logic signed [31:0] b_num;
		logic [31:0]        b_den;
	} req_t;

	typedef struct packed {
		logic signed [63:0] res_num;
		logic [63:0]        res_den;
		logic [1:0]         status;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_MUL_A,
		S_MUL_B,
		S_MUL_D,
		S_COMB,
		S_ZCHK,
		S_GCD,
		S_DIV,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		MS_A,
		MS_B,
		MS_D
	} mul_sel_t;

	typedef enum logic [1:0] {
		K_OK,
		K_ERR,
		K_ZERO
	} kind_t;

	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     comb;
		logic     gcd_step;
		logic     div_init;
		logic     div_step;
		logic     emit;
		kind_t    kind;
	} cmd_t;

	typedef struct packed {
		logic err;
		logic zero_mag;
		logic gcd_done;
		logic div_last;
	} sts_t;

endpackage

// ----- rtl/core/rational_arith_reduce.sv -----
// ----------------------------------------------------------------------------
// rational_arith_reduce
// Exact add, subtract, multiply or divide of two fractions, reduced by GCD.
// ----------------------------------------------------------------------------
// Usage: drive req and raise start while busy is low; the transfer takes
// place at that clock edge and busy rises on the next cycle. One result
// follows per transfer: done is high for exactly one cycle with rsp valid.
// The receiver cannot stall, so rsp must be captured in that cycle.
// Flow: a zero denominator or division by zero ends after the check, a
// zero result after the combine step; otherwise the binary GCD runs (one
// shift or subtract-and-shift per cycle) and then the dual restoring
// divider gives one quotient bit of numerator and denominator per cycle.
// One item is in work at a time; a new start may be given in the cycle
// that done is high.
// Reset (arst_n low) returns the controller to idle and clears done.
// ----------------------------------------------------------------------------
module rational_arith_reduce #(
	parameter int OPERAND_WIDTH = rar_pkg::DEF_OPERAND_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  rar_pkg::req_t req,
	output logic          done,
	output rar_pkg::rsp_t rsp
);
	import rar_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rar_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	rar_dp #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

// ----- rtl/core/rar_dp.sv -----
// ----------------------------------------------------------------------------
// rar_dp
// Datapath: operand registers, shared multiplier, sign-magnitude combine,
// binary GCD, dual restoring divider and result register.
// ----------------------------------------------------------------------------
module rar_dp #(
	parameter int OPERAND_WIDTH = rar_pkg::DEF_OPERAND_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  rar_pkg::req_t req,
	input  rar_pkg::cmd_t cmd,
	output rar_pkg::sts_t sts,
	output logic          done,
	output rar_pkg::rsp_t rsp
);
	import rar_pkg::*;

	localparam int W  = OPERAND_WIDTH;
	localparam int PW = 2 * W;
	localparam int CW = $clog2(PW);

	logic [1:0]    fn_q;
	logic          an_q, bn_q;
	logic [W-1:0]  am_q, bm_q, ad_q, bd_q;
	logic [PW-1:0] pa_q, pb_q, pd_q;
	logic [PW-1:0] mg_q, dn_q, x_q, y_q, g_q;
	logic [CW-1:0] k_q, cnt_q;
	logic          rn_q;
	logic [PW-1:0] qn_q, qd_q;
	logic [PW:0]   rmn_q, rmd_q;
	logic          done_q;
	rsp_t          rsp_q;

	logic [W-1:0]  a_raw, b_raw, a_mag, b_mag;
	logic [W-1:0]  mul_x, mul_y;
	logic [PW-1:0] prod;
	logic          bn_eff, sum_neg;
	logic [PW-1:0] sum_mag;
	logic [PW:0]   tn, td;
	logic [63:0]   qn64, qd64, lim;

	assign a_raw = req.a_num[W-1:0];
	assign b_raw = req.b_num[W-1:0];
	assign a_mag = a_raw[W-1] ? (~a_raw + 1'b1) : a_raw;
	assign b_mag = b_raw[W-1] ? (~b_raw + 1'b1) : b_raw;

	always_comb begin
		case (cmd.mul_sel)
			MS_A: begin
				mul_x = am_q;
				mul_y = (fn_q == FN_MUL) ? bm_q : bd_q;
			end
			MS_B: begin
				mul_x = bm_q;
				mul_y = ad_q;
			end
			MS_D: begin
				mul_x = ad_q;
				mul_y = (fn_q == FN_DIV) ? bm_q : bd_q;
			end
			default: begin
				mul_x = am_q;
				mul_y = bd_q;
			end
		endcase
	end
	assign prod = PW'(mul_x) * PW'(mul_y);

	always_comb begin
		bn_eff = (fn_q == FN_SUB) ? ~bn_q : bn_q;
		if (an_q == bn_eff) begin
			sum_neg = an_q;
			sum_mag = pa_q + pb_q;
		end else if (pa_q >= pb_q) begin
			sum_neg = an_q;
			sum_mag = pa_q - pb_q;
		end else begin
			sum_neg = bn_eff;
			sum_mag = pb_q - pa_q;
		end
	end

	assign tn = {rmn_q[PW-1:0], qn_q[PW-1]};
	assign td = {rmd_q[PW-1:0], qd_q[PW-1]};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fn_q <= req.func;
			an_q <= a_raw[W-1];
			bn_q <= b_raw[W-1];
			am_q <= a_mag;
			bm_q <= b_mag;
			ad_q <= req.a_den[W-1:0];
			bd_q <= req.b_den[W-1:0];
		end
		if (cmd.mul_en) begin
			case (cmd.mul_sel)
				MS_A:    pa_q <= prod;
				MS_B:    pb_q <= prod;
				MS_D:    pd_q <= prod;
				default: pa_q <= prod;
			endcase
		end
		if (cmd.comb) begin
			if (fn_q == FN_ADD || fn_q == FN_SUB) begin
				mg_q <= sum_mag;
				x_q  <= sum_mag;
				rn_q <= sum_neg;
			end else begin
				mg_q <= pa_q;
				x_q  <= pa_q;
				rn_q <= an_q ^ bn_q;
			end
			dn_q <= pd_q;
			y_q  <= pd_q;
			k_q  <= '0;
		end
		if (cmd.gcd_step) begin
			if (!x_q[0] && !y_q[0]) begin
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!x_q[0]) begin
				x_q <= x_q >> 1;
			end else if (!y_q[0]) begin
				y_q <= y_q >> 1;
			end else if (x_q > y_q) begin
				x_q <= (x_q - y_q) >> 1;
			end else begin
				y_q <= (y_q - x_q) >> 1;
			end
		end
		if (cmd.div_init) begin
			g_q   <= x_q << k_q;
			qn_q  <= mg_q;
			qd_q  <= dn_q;
			rmn_q <= '0;
			rmd_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
			if (tn >= {1'b0, g_q}) begin
				rmn_q <= tn - {1'b0, g_q};
				qn_q  <= {qn_q[PW-2:0], 1'b1};
			end else begin
				rmn_q <= tn;
				qn_q  <= {qn_q[PW-2:0], 1'b0};
			end
			if (td >= {1'b0, g_q}) begin
				rmd_q <= td - {1'b0, g_q};
				qd_q  <= {qd_q[PW-2:0], 1'b1};
			end else begin
				rmd_q <= td;
				qd_q  <= {qd_q[PW-2:0], 1'b0};
			end
		end
	end

	assign qn64 = 64'(qn_q);
	assign qd64 = 64'(qd_q);
	assign lim  = rn_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			case (cmd.kind)
				K_ERR: begin
					rsp_q.res_num <= '0;
					rsp_q.res_den <= '0;
					rsp_q.status  <= ST_ZDIV;
				end
				K_ZERO: begin
					rsp_q.res_num <= '0;
					rsp_q.res_den <= 64'd1;
					rsp_q.status  <= ST_OK;
				end
				default: begin
					if (qn64 > lim) begin
						rsp_q.res_num <= '0;
						rsp_q.res_den <= '0;
						rsp_q.status  <= ST_OVF;
					end else begin
						rsp_q.res_num <= rn_q ? (64'd0 - qn64) : qn64;
						rsp_q.res_den <= qd64;
						rsp_q.status  <= ST_OK;
					end
				end
			endcase
		end
	end

	assign sts.err      = (ad_q == '0) || (bd_q == '0) || (fn_q == FN_DIV && bm_q == '0);
	assign sts.zero_mag = (x_q == '0);
	assign sts.gcd_done = (x_q == y_q);
	assign sts.div_last = (cnt_q == CW'(PW - 1));
	assign done = done_q;
	assign rsp  = rsp_q;

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rsp_q.status != 2'd3))
		else $error("illegal status");
	a_ok_den: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && rsp_q.status == ST_OK) |-> (rsp_q.res_den != '0))
		else $error("zero denominator on ok result");

endmodule

// ----- rtl/core/rar_ctrl.sv -----
// ----------------------------------------------------------------------------
// rar_ctrl
// Controller: sequences multiply, combine, GCD and divide steps.
// ----------------------------------------------------------------------------
module rar_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  rar_pkg::sts_t sts,
	output rar_pkg::cmd_t cmd
);
	import rar_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.mul_sel = MS_A;
		cmd.kind    = K_OK;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.err) begin
					cmd.emit = 1'b1;
					cmd.kind = K_ERR;
					state_d  = S_IDLE;
				end else begin
					state_d = S_MUL_A;
				end
			end
			S_MUL_A: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_A;
				state_d     = S_MUL_B;
			end
			S_MUL_B: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_B;
				state_d     = S_MUL_D;
			end
			S_MUL_D: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_D;
				state_d     = S_COMB;
			end
			S_COMB: begin
				cmd.comb = 1'b1;
				state_d  = S_ZCHK;
			end
			S_ZCHK: begin
				if (sts.zero_mag) begin
					cmd.emit = 1'b1;
					cmd.kind = K_ZERO;
					state_d  = S_IDLE;
				end else begin
					state_d = S_GCD;
				end
			end
			S_GCD: begin
				if (sts.gcd_done) begin
					cmd.div_init = 1'b1;
					state_d      = S_DIV;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				cmd.emit = 1'b1;
				cmd.kind = K_OK;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start) |=> (state_q == S_CHECK))
		else $error("transfer not taken");
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (state_q == S_IDLE))
		else $error("no return to idle after result");
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && sts.div_last) |=> (state_q == S_DONE))
		else $error("divide did not finish");

endmodule

// ----- dv/rar_checker.sv -----
// ----------------------------------------------------------------------------
// rar_checker
// Watches request and response transfers of the rational arithmetic block,
// computes the reduced fraction for each request and compares each response.
// ----------------------------------------------------------------------------
module rar_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  rar_pkg::req_t req,
	input  logic          done,
	input  rar_pkg::rsp_t rsp,
	output int            errors,
	output int            pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import rar_pkg::*;

	rsp_t fraction_q[$];

	function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
		logic [63:0] a, b, t;
		a = (x > y) ? x : y;
		b = (x > y) ? y : x;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	function automatic logic [63:0] mag32(logic [31:0] v, output logic neg);
		neg = v[31];
		return neg ? ({32'd0, ~v} + 64'd1) : {32'd0, v};
	endfunction

	function automatic rsp_t reduce_fraction(req_t r);
		rsp_t o;
		logic an, bn, rn;
		logic [63:0] am, bm, ad, bd, p, q, mag, den, g, lim;
		o = '0;
		am = mag32(r.a_num, an);
		bm = mag32(r.b_num, bn);
		ad = {32'd0, r.a_den};
		bd = {32'd0, r.b_den};
		if (ad == 0 || bd == 0 || (func_t'(r.func) == FN_DIV && bm == 0)) begin
			o.status = ST_ZDIV;
			return o;
		end
		rn = an ^ bn;
		den = ad * bd;
		case (func_t'(r.func))
			FN_ADD, FN_SUB: begin
				p = am * bd;
				q = bm * ad;
				if (func_t'(r.func) == FN_SUB) bn = !bn;
				if (an == bn) begin
					rn = an; mag = p + q;
				end else if (p >= q) begin
					rn = an; mag = p - q;
				end else begin
					rn = bn; mag = q - p;
				end
			end
			FN_MUL: mag = am * bm;
			default: begin
				mag = am * bd;
				den = ad * bm;
			end
		endcase
		if (mag == 0) begin
			o.res_den = 64'd1;
			o.status = ST_OK;
			return o;
		end
		g = gcd64(mag, den);
		mag = mag / g;
		den = den / g;
		lim = rn ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
		if (mag > lim) begin
			o.status = ST_OVF;
			return o;
		end
		o.res_num = rn ? (64'd0 - mag) : mag;
		o.res_den = den;
		o.status = ST_OK;
		return o;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	assign pending = fraction_q.size();

	initial errors = 0;

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (done) begin
				if (fraction_q.size() == 0) begin
					report("unexpected response", rsp.res_num, 64'd0);
				end else begin
					want = fraction_q.pop_front();
					if (rsp.res_num !== want.res_num)
						report("res_num", rsp.res_num, want.res_num);
					if (rsp.res_den !== want.res_den)
						report("res_den", rsp.res_den, want.res_den);
					if (rsp.status !== want.status)
						report("status", {62'd0, rsp.status}, {62'd0, want.status});
				end
			end
			if (start && !busy)
				fraction_q.push_back(reduce_fraction(req));
		end
	end
endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Regression for rational_arith_reduce: directed corner fractions, then
// random requests with random gaps; a checker module scores each response.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rar_pkg::*;

	logic  clk, arst_n, start, busy, done;
	req_t  req;
	rsp_t  rsp;
	int    errors, pending;
	int    cycles;

	rational_arith_reduce uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	rar_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 2000000) begin
				$display("rational_arith_reduce regression: fail");
				$finish;
			end
		end
	end

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'h8000_0000;
			2: return 32'h7fff_ffff;
			3: return 32'hffff_ffff;
			4: return 32'd1;
			5: return $urandom_range(0, 20) - 10;
			6: return $urandom_range(1, 1000);
			default: return $urandom();
		endcase
	endfunction

	task automatic send(func_t f, logic [31:0] an, logic [31:0] ad,
			logic [31:0] bn, logic [31:0] bd);
		int gap;
		gap = $urandom_range(0, 7);
		repeat (gap) @(posedge clk);
		while (busy) @(posedge clk);
		req <= '{func: f, a_num: an, a_den: ad, b_num: bn, b_den: bd};
		start <= 1'b1;
		@(posedge clk);
		start <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [31:0] d;
		start = 0;
		req = '0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int f = 0; f < 4; f++) begin
			send(func_t'(f), 32'h8000_0000, 32'hffff_ffff, 32'h8000_0000, 32'd1);
			send(func_t'(f), 32'h7fff_ffff, 32'd1, 32'h8000_0000, 32'hffff_ffff);
			send(func_t'(f), 32'd3, 32'd0, 32'd1, 32'd2);
			send(func_t'(f), 32'd1, 32'd2, 32'hffff_ffff, 32'd2);
			send(func_t'(f), 32'd0, 32'd5, 32'd0, 32'd7);
		end
		send(FN_DIV, 32'd5, 32'd3, 32'd0, 32'd9);
		send(FN_ADD, 32'd1, 32'd2, 32'd1, 32'd0);
		send(FN_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
		send(FN_DIV, 32'd4, 32'd6, 32'hffff_fffe, 32'd3);
		for (int i = 0; i < 800; i++) begin
			d = pick_word();
			if ($urandom_range(0, 9) != 0 && d == 0) d = 32'd1;
			send(func_t'($urandom_range(0, 3)), pick_word(), d, pick_word(),
				($urandom_range(0, 15) == 0) ? 32'd0 : (pick_word() | 32'd1));
		end
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("rational_arith_reduce regression: pass");
		else
			$display("rational_arith_reduce regression: fail");
		$finish;
	end
endmodule

// ----- files.f -----
rtl/core/rar_pkg.sv
rtl/core/rar_dp.sv
rtl/core/rar_ctrl.sv
rtl/core/rational_arith_reduce.sv
dv/rar_checker.sv
dv/tb_top.sv
